>>> sv/lfdab_pkg.sv
// Package with shared types and constants of the lidar deframer and angle binner.
package lfdab_pkg;

    localparam int NumBins       = 360;
    localparam int BinsPerResult = 8;
    localparam int NumGroups     = (NumBins + BinsPerResult - 1) / BinsPerResult;
    localparam int BinAddrW      = 9;
    localparam int GroupW        = 6;

    localparam logic [1:0] CfgSync    = 2'd0;
    localparam logic [1:0] CfgMaxLen  = 2'd1;
    localparam logic [1:0] CfgWrapLow = 2'd2;
    localparam logic [1:0] CfgWrapHi  = 2'd3;

    localparam logic [7:0]  SyncReset    = 8'hAD;
    localparam logic [15:0] MaxLenReset  = 16'd200;
    localparam logic [8:0]  WrapLowReset = 9'd45;
    localparam logic [8:0]  WrapHiReset  = 9'd315;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_CRC     = 2'd2
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BYTE,
        S_DIV,
        S_MOD,
        S_RD_ADDR,
        S_RD_WAIT,
        S_RD_LOAD,
        S_RD_OUT,
        S_STORE,
        S_CLEAR
    } t_seq;

    typedef struct packed {
        logic [GroupW-1:0] group_index;
        logic [15:0]       bin_a;
        logic [15:0]       bin_b;
        logic [15:0]       bin_c;
        logic [15:0]       bin_d;
        logic [15:0]       bin_e;
        logic [15:0]       bin_f;
        logic [15:0]       bin_g;
        logic [15:0]       bin_h;
        logic              last_group;
    } t_result;

endpackage

>>> sv/lfdab_if.sv
// Valid/ready channel interfaces for bytes, results and configuration writes.
interface lfdab_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface lfdab_res_if;
    logic                valid;
    logic                ready;
    lfdab_pkg::t_result  res;
    modport source (output valid, output res, input ready);
    modport sink (input valid, input res, output ready);
endinterface

interface lfdab_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/lidar_frame_deframer_angle_binner.sv
// Top level: frame deframer, sequential angle divider and 360-bin scan memory.
//
//  channel   dir  beat contents
//  i_byte    in   rx_byte
//  o_res     out  group_index, bin_a..bin_h, last_group
//  i_cfg     in   index, data (register write)
//
// Each byte is taken in S_IDLE and handled in S_BYTE. A sample's last byte then runs
// through the bit-serial divider (34 quotient bits), the modulo 360 step and the bin
// store.
// A scan readout reads the bin memory per group (address, wait and load per bin) and
// holds the output beat until it is taken, for 45 groups, then clears the bin memory.
// After reset a clearing pass over the bin memory runs before the first byte is taken.
// The byte side is not ready while an item is at work; a stalled result holds.
module lidar_frame_deframer_angle_binner (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lfdab_byte_if.sink   i_byte,
    lfdab_res_if.source  o_res,
    lfdab_cfg_if.sink    i_cfg
);

    localparam int DivW = 34;

    logic [7:0]  r_sync;
    logic [15:0] r_max_len;
    logic [8:0]  r_wrap_low, r_wrap_hi;

    logic [7:0]  r_win [8];
    logic [3:0]  r_fill;
    lfdab_pkg::t_phase r_phase;
    logic [15:0] r_len, r_pos, r_start, r_total;
    logic [7:0]  r_hi_byte, r_byte;
    logic [8:0]  r_last_deg;
    logic [1:0]  r_rem3;
    logic [15:0] r_idx;

    lfdab_pkg::t_seq r_seq, n_seq;

    logic [DivW-1:0] r_num, r_quo;
    logic [DivW:0]   r_rmd;
    logic [23:0]     r_den;
    logic [5:0]      r_cnt;
    logic [8:0]      r_deg;
    logic            r_wrap;
    logic [15:0]     r_dist;

    logic [15:0]     r_mem [lfdab_pkg::NumBins];
    logic [15:0]     r_rd_data;
    logic [8:0]      r_addr;
    logic [2:0]      r_lane;
    logic [15:0]     r_lanes [8];
    logic [5:0]      r_group;
    logic            r_out_valid;
    logic            r_wr_en;
    logic [8:0]      r_wr_addr;
    logic [15:0]     r_wr_data;

    logic byte_acc, out_acc;
    assign byte_acc = i_byte.valid && i_byte.ready;
    assign out_acc  = o_res.valid && o_res.ready;
    assign i_byte.ready = (r_seq == lfdab_pkg::S_IDLE);
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync     <= lfdab_pkg::SyncReset;
            r_max_len  <= lfdab_pkg::MaxLenReset;
            r_wrap_low <= lfdab_pkg::WrapLowReset;
            r_wrap_hi  <= lfdab_pkg::WrapHiReset;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                lfdab_pkg::CfgSync:    r_sync     <= i_cfg.data[7:0];
                lfdab_pkg::CfgMaxLen:  r_max_len  <= i_cfg.data;
                lfdab_pkg::CfgWrapLow: r_wrap_low <= i_cfg.data[8:0];
                lfdab_pkg::CfgWrapHi:  r_wrap_hi  <= i_cfg.data[8:0];
                default: ;
            endcase
        end
    end

    // Trial subtraction of the restoring divider.
    logic [DivW:0] div_shift;
    logic [DivW:0] div_diff;
    assign div_shift = {r_rmd[DivW-1:0], r_num[DivW-1]};
    assign div_diff  = div_shift - {{(DivW-23){1'b0}}, r_den};

    logic [DivW-1:0] num_full;
    assign num_full = DivW'({r_total, 1'b0}) * DivW'(r_start)
                    + DivW'(r_idx) * DivW'(4500);

    // Sliding window of the received bytes and the header length taken from it.
    logic [7:0] win_next [8];
    logic [15:0] hdr_len;
    always_comb begin
        for (int k = 0; k < 8; k++) win_next[k] = r_win[k];
        if (r_fill < 4'd8) begin
            win_next[r_fill[2:0]] = r_byte;
        end else begin
            for (int k = 0; k < 7; k++) win_next[k] = r_win[k+1];
            win_next[7] = r_byte;
        end
        hdr_len = {win_next[6], win_next[7]};
    end

    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            lfdab_pkg::S_IDLE:    if (byte_acc) n_seq = lfdab_pkg::S_BYTE;
            lfdab_pkg::S_BYTE: begin
                if (r_phase == lfdab_pkg::PH_PAYLOAD && r_pos >= 16'd5
                        && r_idx < r_total && r_rem3 == 2'd2) begin
                    n_seq = lfdab_pkg::S_DIV;
                end else begin
                    n_seq = lfdab_pkg::S_IDLE;
                end
            end
            lfdab_pkg::S_DIV:     if (r_cnt == 6'd0) n_seq = lfdab_pkg::S_MOD;
            lfdab_pkg::S_MOD: begin
                if (r_quo < 34'd360) begin
                    n_seq = (r_quo[8:0] < r_wrap_low && r_last_deg > r_wrap_hi)
                          ? lfdab_pkg::S_RD_ADDR : lfdab_pkg::S_STORE;
                end
            end
            lfdab_pkg::S_RD_ADDR: n_seq = lfdab_pkg::S_RD_WAIT;
            lfdab_pkg::S_RD_WAIT: n_seq = lfdab_pkg::S_RD_LOAD;
            lfdab_pkg::S_RD_LOAD: begin
                if (r_lane == 3'd7) n_seq = lfdab_pkg::S_RD_OUT;
                else n_seq = lfdab_pkg::S_RD_ADDR;
            end
            lfdab_pkg::S_RD_OUT: begin
                if (out_acc) begin
                    n_seq = (r_group == 6'(lfdab_pkg::NumGroups - 1))
                          ? lfdab_pkg::S_CLEAR : lfdab_pkg::S_RD_ADDR;
                end
            end
            lfdab_pkg::S_CLEAR: begin
                if (r_addr == 9'(lfdab_pkg::NumBins - 1)) begin
                    n_seq = r_wrap ? lfdab_pkg::S_STORE : lfdab_pkg::S_IDLE;
                end
            end
            lfdab_pkg::S_STORE:   n_seq = lfdab_pkg::S_IDLE;
            default:              n_seq = lfdab_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= lfdab_pkg::S_CLEAR;
            r_wrap <= 1'b0;
            r_addr <= '0;
            r_fill <= '0;
            r_phase <= lfdab_pkg::PH_HUNT;
            r_len <= '0;
            r_pos <= '0;
            r_start <= '0;
            r_total <= '0;
            r_hi_byte <= '0;
            r_last_deg <= '0;
            r_out_valid <= 1'b0;
            r_group <= '0;
            r_lane <= '0;
            r_wr_en <= 1'b0;
            for (int k = 0; k < 8; k++) r_win[k] <= '0;
        end else begin
            r_seq <= n_seq;
            r_wr_en <= 1'b0;
            unique case (r_seq)
                lfdab_pkg::S_IDLE: begin
                    if (byte_acc) begin
                        r_byte <= i_byte.rx_byte;
                        r_rem3 <= r_rem3;
                    end
                end
                lfdab_pkg::S_BYTE: begin
                    if (r_phase == lfdab_pkg::PH_PAYLOAD) begin
                        if (r_pos == 16'd3) r_start <= {r_byte, 8'd0};
                        else if (r_pos == 16'd4) r_start <= {r_start[15:8], r_byte};
                        else if (r_pos >= 16'd5 && r_idx < r_total && r_rem3 == 2'd1)
                            r_hi_byte <= r_byte;
                        if (r_pos >= 16'd5 && r_idx < r_total && r_rem3 == 2'd2) begin
                            r_dist <= {r_hi_byte, r_byte};
                            r_num <= num_full;
                            // 200 n as 128 n + 64 n + 8 n.
                            r_den <= {1'b0, r_total, 7'd0} + {2'd0, r_total, 6'd0}
                                   + {5'd0, r_total, 3'd0};
                            r_rmd <= '0;
                            r_cnt <= 6'(DivW);
                        end
                        // Track sample index and byte lane within the sample.
                        if (r_pos >= 16'd5) begin
                            if (r_rem3 == 2'd2) begin
                                r_rem3 <= 2'd0;
                                r_idx <= r_idx + 16'd1;
                            end else begin
                                r_rem3 <= r_rem3 + 2'd1;
                            end
                        end
                        if ((r_pos + 16'd1) >= r_len) begin
                            r_phase <= lfdab_pkg::PH_CRC;
                            r_pos <= '0;
                        end else begin
                            r_pos <= r_pos + 16'd1;
                        end
                    end else if (r_phase == lfdab_pkg::PH_CRC) begin
                        if (r_pos >= 16'd1) begin
                            r_pos <= '0;
                            r_phase <= lfdab_pkg::PH_HUNT;
                            r_fill <= '0;
                            for (int k = 0; k < 8; k++) r_win[k] <= '0;
                        end else begin
                            r_pos <= r_pos + 16'd1;
                        end
                    end else begin
                        r_phase <= lfdab_pkg::PH_HUNT;
                        for (int k = 0; k < 8; k++) r_win[k] <= win_next[k];
                        if (r_fill < 4'd8) r_fill <= r_fill + 4'd1;
                        if ((r_fill >= 4'd7) && win_next[5] == r_sync) begin
                            if (hdr_len > r_max_len) begin
                                r_fill <= '0;
                                for (int k = 0; k < 8; k++) r_win[k] <= '0;
                            end else begin
                                r_len <= hdr_len;
                                r_pos <= '0;
                                r_idx <= '0;
                                r_rem3 <= 2'd0;
                                r_total <= (hdr_len >= 16'd5)
                                    ? 16'((32'(hdr_len) - 32'd5) * 32'd43691 >> 17) : 16'd0;
                                r_phase <= (hdr_len == 16'd0)
                                    ? lfdab_pkg::PH_CRC : lfdab_pkg::PH_PAYLOAD;
                            end
                        end
                    end
                end
                lfdab_pkg::S_DIV: begin
                    if (r_cnt != 6'd0) begin
                        r_num <= {r_num[DivW-2:0], 1'b0};
                        if (!div_diff[DivW]) begin
                            r_rmd <= div_diff;
                            r_quo <= {r_quo[DivW-2:0], 1'b1};
                        end else begin
                            r_rmd <= div_shift;
                            r_quo <= {r_quo[DivW-2:0], 1'b0};
                        end
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                lfdab_pkg::S_MOD: begin
                    // Repeated subtraction by powers of two times 360.
                    if (r_quo >= 34'd360) begin
                        if (r_quo >= (34'd360 << 24)) r_quo <= r_quo - (34'd360 << 24);
                        else if (r_quo >= (34'd360 << 16)) r_quo <= r_quo - (34'd360 << 16);
                        else if (r_quo >= (34'd360 << 8)) r_quo <= r_quo - (34'd360 << 8);
                        else if (r_quo >= (34'd360 << 4)) r_quo <= r_quo - (34'd360 << 4);
                        else r_quo <= r_quo - 34'd360;
                    end
                    r_deg <= r_quo[8:0];
                    r_wrap <= 1'b0;
                    r_addr <= '0;
                    r_group <= '0;
                    r_lane <= '0;
                end
                lfdab_pkg::S_RD_ADDR: r_wrap <= 1'b1;
                lfdab_pkg::S_RD_WAIT: ;
                lfdab_pkg::S_RD_LOAD: begin
                    r_lanes[r_lane] <= (r_addr < 9'(lfdab_pkg::NumBins)) ? r_rd_data : 16'd0;
                    r_lane <= r_lane + 3'd1;
                    r_addr <= r_addr + 9'd1;
                    if (r_lane == 3'd7) r_out_valid <= 1'b1;
                end
                lfdab_pkg::S_RD_OUT: begin
                    if (out_acc) begin
                        r_out_valid <= 1'b0;
                        r_group <= r_group + 6'd1;
                        if (r_group == 6'(lfdab_pkg::NumGroups - 1)) r_addr <= '0;
                    end
                end
                lfdab_pkg::S_CLEAR: begin
                    r_wr_en <= 1'b1;
                    r_wr_addr <= r_addr;
                    r_wr_data <= '0;
                    r_addr <= (r_addr == 9'(lfdab_pkg::NumBins - 1)) ? 9'd0 : r_addr + 9'd1;
                end
                lfdab_pkg::S_STORE: begin
                    r_wrap <= 1'b0;
                    r_last_deg <= r_deg;
                    if (r_dist != 16'd0) begin
                        r_wr_en <= 1'b1;
                        r_wr_addr <= r_deg;
                        r_wr_data <= r_dist;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_wr_en) r_mem[r_wr_addr] <= r_wr_data;
        if (r_addr < 9'(lfdab_pkg::NumBins)) r_rd_data <= r_mem[r_addr];
        else r_rd_data <= '0;
    end

    assign o_res.valid = r_out_valid;
    always_comb begin
        o_res.res.group_index = r_group;
        o_res.res.bin_a = r_lanes[0];
        o_res.res.bin_b = r_lanes[1];
        o_res.res.bin_c = r_lanes[2];
        o_res.res.bin_d = r_lanes[3];
        o_res.res.bin_e = r_lanes[4];
        o_res.res.bin_f = r_lanes[5];
        o_res.res.bin_g = r_lanes[6];
        o_res.res.bin_h = r_lanes[7];
        o_res.res.last_group = (r_group == 6'(lfdab_pkg::NumGroups - 1));
    end

endmodule
